// ----- hdl/tx_context_round_robin_scheduler_macros.svh -----
// Assertion macros used by the scheduler back end (txrr_back).
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef TX_CONTEXT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TX_CONTEXT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TXRR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TXRR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/txrr_pkg.sv -----
// Shared types and constants of the transmit context round-robin scheduler.
// No dependencies; every other scheduler file but the assertion macro header refers to this package.
`default_nettype none

package txrr_pkg;

	localparam int INDEX_BITS     = 20;
	localparam int LEN_BITS       = INDEX_BITS + 1;
	localparam int DESC_BITS      = 16;
	localparam int ADDR_BITS      = 32;
	localparam int SEQ_BITS       = 32;
	localparam int CTX_FIELD_BITS = 5;
	localparam int POS_SHIFT      = 5;
	localparam int FIRST_CONTEXT  = 1;

	// Request opcodes.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_BUMP   = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_ISSUED  = 2'd1;
	localparam logic [1:0] STAT_NONE    = 2'd2;
	localparam logic [1:0] STAT_IGNORED = 2'd3;

	// Work class decided by the front end.
	typedef enum logic [1:0] {
		K_LOAD   = 2'd0,
		K_UPDATE = 2'd1,
		K_BUMP   = 2'd2,
		K_IGNORE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [CTX_FIELD_BITS-1:0] ctx;
		logic [ADDR_BITS-1:0]      ring_base;
		logic [LEN_BITS-1:0]       ring_len;
		logic [INDEX_BITS-1:0]     cons_index;
		logic [INDEX_BITS-1:0]     prod_index;
		logic [DESC_BITS-1:0]      desc_index;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [DESC_BITS-1:0]      cmd_desc;
		logic [SEQ_BITS-1:0]       cmd_seq;
		logic [ADDR_BITS-1:0]      cmd_buf_pos;
		logic [CTX_FIELD_BITS-1:0] cmd_ctx;
	} rsp_t;

	// Classified word passed from front to back. For a load, ctx is the slot.
	typedef struct packed {
		kind_t                     kind;
		logic [CTX_FIELD_BITS-1:0] ctx;
		logic [ADDR_BITS-1:0]      base;
		logic [LEN_BITS-1:0]       len;
		logic [INDEX_BITS-1:0]     cons;
		logic [INDEX_BITS-1:0]     prod;
		logic [DESC_BITS-1:0]      desc;
	} work_t;

endpackage

`default_nettype wire

// ----- hdl/txrr_front.sv -----
// Front end: accepts request words, owns the active context count and classifies.
// Depends on txrr_pkg.
`default_nettype none

module txrr_front #(
	parameter int NUM_CONTEXTS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            busy,
	input  wire txrr_pkg::req_t  req,
	output logic                 push,
	output txrr_pkg::work_t      work
);

	localparam int AC_W = $clog2(NUM_CONTEXTS + 1);

	logic [AC_W-1:0] active_count_q;
	logic            accept;

	assign accept = start && !busy;
	assign push   = accept;

	always_comb begin
		work.kind = txrr_pkg::K_IGNORE;
		work.ctx  = req.ctx;
		work.base = req.ring_base;
		work.len  = req.ring_len;
		work.cons = req.cons_index;
		work.prod = req.prod_index;
		work.desc = req.desc_index;
		unique case (req.op)
			txrr_pkg::OP_LOAD: begin
				if (active_count_q < AC_W'(NUM_CONTEXTS)) begin
					work.kind = txrr_pkg::K_LOAD;
					work.ctx  = txrr_pkg::CTX_FIELD_BITS'(active_count_q);
				end
			end
			txrr_pkg::OP_UPDATE: begin
				// Only an already active context, never context zero.
				if (32'(req.ctx) >= 32'(txrr_pkg::FIRST_CONTEXT) &&
				    32'(req.ctx) < 32'(active_count_q)) begin
					work.kind = txrr_pkg::K_UPDATE;
				end
			end
			txrr_pkg::OP_BUMP: begin
				work.kind = txrr_pkg::K_BUMP;
			end
			default: begin
				work.kind = txrr_pkg::K_IGNORE;
			end
		endcase
	end

	// A zero-length load leaves the count alone so the next load reuses the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= AC_W'(txrr_pkg::FIRST_CONTEXT);
		end else if (accept && work.kind == txrr_pkg::K_LOAD && req.ring_len != '0) begin
			active_count_q <= active_count_q + AC_W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/txrr_queue.sv -----
// Two-word queue decoupling the front end from the back end.
// Depends on txrr_pkg.
`default_nettype none

module txrr_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire txrr_pkg::work_t  push_data,
	input  wire logic             pop,
	output txrr_pkg::work_t       pop_data,
	output logic                  not_empty,
	output logic                  full
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	txrr_pkg::work_t entries [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data  = entries[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CNT_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/txrr_back.sv -----
// Back end: ring record tables, round-robin context FIFO and command sequencer.
// Depends on txrr_pkg and the assertion macro header.
`default_nettype none
`include "tx_context_round_robin_scheduler_macros.svh"

module txrr_back #(
	parameter int NUM_CONTEXTS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid,
	input  wire txrr_pkg::work_t  work,
	output logic                  pop,
	output logic                  done,
	output txrr_pkg::rsp_t        rsp
);

	localparam int CTX_W = $clog2(NUM_CONTEXTS);
	localparam int IW    = txrr_pkg::INDEX_BITS;
	localparam int LW    = txrr_pkg::LEN_BITS;
	localparam int AW    = txrr_pkg::ADDR_BITS;
	localparam int SW    = txrr_pkg::SEQ_BITS;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_UPD_EX = 4'b0010,
		S_BMP_RD = 4'b0100,
		S_BMP_EX = 4'b1000
	} state_t;

	function automatic logic [CTX_W-1:0] wrap_next(input logic [CTX_W-1:0] p);
		return (p == CTX_W'(NUM_CONTEXTS - 1)) ? '0 : p + CTX_W'(1);
	endfunction

	// Ring record tables and the round-robin FIFO storage.
	logic [AW-1:0]    base_mem [NUM_CONTEXTS];
	logic [LW-1:0]    len_mem  [NUM_CONTEXTS];
	logic [IW-1:0]    cons_mem [NUM_CONTEXTS];
	logic [IW-1:0]    prod_mem [NUM_CONTEXTS];
	logic [CTX_W-1:0] fifo_mem [NUM_CONTEXTS];

	logic [AW-1:0]    base_rd_q;
	logic [LW-1:0]    len_rd_q;
	logic [IW-1:0]    cons_rd_q;
	logic [IW-1:0]    prod_rd_q;
	logic [CTX_W-1:0] fifo_rd_q;

	state_t              state_q, state_d;
	txrr_pkg::work_t     cur_q;
	logic [CTX_W-1:0]    idx_q;
	logic [CTX_W-1:0]    head_q;
	logic [CTX_W-1:0]    tail_q;
	logic [NUM_CONTEXTS-1:0] queued_q;
	logic [SW-1:0]       seq_q;
	logic                done_q, done_d;
	txrr_pkg::rsp_t      rsp_q, rsp_d;

	logic [CTX_W-1:0] head_ctx;
	logic [CTX_W-1:0] cur_ctx;
	logic [CTX_W-1:0] tbl_ra;
	logic [CTX_W-1:0] tbl_wa;
	logic [CTX_W-1:0] push_ctx;
	logic             fifo_empty;
	logic             load_wr;
	logic             cons_we;
	logic             prod_we;
	logic [IW-1:0]    cons_wd;
	logic [IW-1:0]    prod_wd;
	logic [LW-1:0]    ring_mask;
	logic [IW-1:0]    cons_next;
	logic [AW-1:0]    buf_pos;
	logic             push_en;

	assign head_ctx   = work.ctx[CTX_W-1:0];
	assign cur_ctx    = cur_q.ctx[CTX_W-1:0];
	assign fifo_empty = head_q == tail_q;
	assign pop        = (state_q == S_IDLE) && valid;
	assign load_wr    = pop && work.kind == txrr_pkg::K_LOAD;

	// Consumer advance wraps within the ring only when the stored length is a power of two.
	assign ring_mask = len_rd_q - LW'(1);
	assign cons_next = (cons_rd_q + IW'(1)) & ring_mask[IW-1:0];
	assign buf_pos   = base_rd_q + (AW'(cons_rd_q) << txrr_pkg::POS_SHIFT);

	assign tbl_ra = (state_q == S_BMP_RD) ? fifo_rd_q : head_ctx;
	assign tbl_wa = load_wr ? head_ctx : ((state_q == S_BMP_EX) ? idx_q : cur_ctx);

	assign cons_we = load_wr || state_q == S_BMP_EX;
	assign cons_wd = load_wr ? work.cons : cons_next;
	assign prod_we = load_wr || state_q == S_UPD_EX;
	assign prod_wd = load_wr ? work.prod : cur_q.prod;

	assign push_ctx = (state_q == S_BMP_EX) ? idx_q : cur_ctx;
	assign push_en  = (state_q == S_UPD_EX && !queued_q[cur_ctx] && cur_q.prod != cons_rd_q) ||
	                  (state_q == S_BMP_EX && prod_rd_q != cons_next);

	always_ff @(posedge clk) begin
		if (load_wr) begin
			base_mem[tbl_wa] <= work.base;
			len_mem[tbl_wa]  <= work.len;
		end
		if (cons_we) begin
			cons_mem[tbl_wa] <= cons_wd;
		end
		if (prod_we) begin
			prod_mem[tbl_wa] <= prod_wd;
		end
		if (push_en) begin
			fifo_mem[tail_q] <= push_ctx;
		end
		base_rd_q <= base_mem[tbl_ra];
		len_rd_q  <= len_mem[tbl_ra];
		cons_rd_q <= cons_mem[tbl_ra];
		prod_rd_q <= prod_mem[tbl_ra];
		fifo_rd_q <= fifo_mem[head_q];
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		rsp_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (valid) begin
					unique case (work.kind)
						txrr_pkg::K_LOAD: begin
							done_d       = 1'b1;
							rsp_d.status = txrr_pkg::STAT_DONE;
						end
						txrr_pkg::K_UPDATE: begin
							state_d = S_UPD_EX;
						end
						txrr_pkg::K_BUMP: begin
							if (fifo_empty) begin
								done_d       = 1'b1;
								rsp_d.status = txrr_pkg::STAT_NONE;
							end else begin
								state_d = S_BMP_RD;
							end
						end
						default: begin
							done_d       = 1'b1;
							rsp_d.status = txrr_pkg::STAT_IGNORED;
						end
					endcase
				end
			end
			S_UPD_EX: begin
				done_d       = 1'b1;
				rsp_d.status = txrr_pkg::STAT_DONE;
				state_d      = S_IDLE;
			end
			S_BMP_RD: begin
				state_d = S_BMP_EX;
			end
			S_BMP_EX: begin
				done_d            = 1'b1;
				rsp_d.status      = txrr_pkg::STAT_ISSUED;
				rsp_d.cmd_desc    = cur_q.desc;
				rsp_d.cmd_seq     = seq_q;
				rsp_d.cmd_buf_pos = buf_pos;
				rsp_d.cmd_ctx     = txrr_pkg::CTX_FIELD_BITS'(idx_q);
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (pop) begin
			cur_q <= work;
		end
		if (state_q == S_BMP_RD) begin
			idx_q <= fifo_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			queued_q <= '0;
			seq_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_BMP_RD) begin
				head_q              <= wrap_next(head_q);
				queued_q[fifo_rd_q] <= 1'b0;
			end
			if (push_en) begin
				tail_q             <= wrap_next(tail_q);
				queued_q[push_ctx] <= 1'b1;
			end
			if (state_q == S_BMP_EX) begin
				seq_q <= seq_q + SW'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`TXRR_ASSERT_IMP(a_pop_nonempty, state_q == S_BMP_RD, head_q != tail_q, "pop from empty FIFO")
	`TXRR_ASSERT_IMP(a_push_unqueued, push_en, !queued_q[push_ctx], "context queued twice")
	`TXRR_ASSERT_IMP(a_issue_origin, done_q && rsp_q.status == txrr_pkg::STAT_ISSUED, $past(state_q == S_BMP_EX), "command issued outside execute step")
	`TXRR_ASSERT_IMP(a_issue_seq, done_q && rsp_q.status == txrr_pkg::STAT_ISSUED, rsp_q.cmd_seq == seq_q - SW'(1), "sequence number out of step")

endmodule

`default_nettype wire

// ----- hdl/tx_context_round_robin_scheduler.sv -----
// Top level of the transmit context round-robin scheduler.
// Depends on txrr_pkg, txrr_front, txrr_queue and txrr_back.
`default_nettype none

// Usage
// A request word on req is taken at a rising edge where start is high and busy is
// low. Opcodes load the next context record, update a producer index, or bump the
// scheduler to issue one command from the next waiting context.
// Every request gives exactly one response word on rsp, marked by done for a
// single cycle; the receiver cannot hold responses off, and they come in request
// order.
// From acceptance a word passes through the queue into the sequencer, which
// registers its response: a load, an ignored request or an empty bump is
// answered from the idle state, a producer update from the update step, and a
// bump that issues a command from the execute step after a table read step.
// The sequencer takes no new word until it is back in idle. A two-word queue
// sits between the front end and the sequencer; busy is high while that queue
// is full.
// After reset no context is active, the next load fills context 1, the context
// FIFO is empty and the sequence number starts at zero. Record table contents are
// unknown until a load writes them.

module tx_context_round_robin_scheduler #(
	parameter int NUM_CONTEXTS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire txrr_pkg::req_t  req,
	output logic                 done,
	output txrr_pkg::rsp_t       rsp
);

	// Classified words between the front end and the sequencer.
	logic            front_push;
	txrr_pkg::work_t front_work;
	txrr_pkg::work_t queue_word;
	logic            queue_valid;
	logic            queue_full;
	logic            back_pop;

	assign busy = queue_full;

	// The front end decides slot and validity at acceptance, so the active
	// context count never has to wait on the sequencer.
	txrr_front #(
		.NUM_CONTEXTS(NUM_CONTEXTS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (queue_full),
		.req   (req),
		.push  (front_push),
		.work  (front_work)
	);

	txrr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_data(front_work),
		.pop      (back_pop),
		.pop_data (queue_word),
		.not_empty(queue_valid),
		.full     (queue_full)
	);

	// The sequencer owns the record tables, the round-robin FIFO and the
	// sequence counter, and registers every response word.
	txrr_back #(
		.NUM_CONTEXTS(NUM_CONTEXTS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (queue_valid),
		.work  (queue_word),
		.pop   (back_pop),
		.done  (done),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire
